FILE: design/pses_pkg.sv
// Shared constants, types and helpers for the packed signed element store.
`default_nettype none

package pses_pkg;

  // Element geometry.
  localparam int ELEM_BITS = 4;
  localparam int CAPACITY  = 1024;
  localparam int BYTE_BITS = 8;

  // Field widths.
  localparam int INDEX_W = 16;
  localparam int WVAL_W  = 8;
  localparam int OUT_W   = 7;
  localparam int COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

  // Byte memory layout, split into an even-byte bank and an odd-byte bank.
  localparam int MEM_BYTES  = (CAPACITY * ELEM_BITS + BYTE_BITS - 1) / BYTE_BITS;
  localparam int BANK_DEPTH = MEM_BYTES / 2 + 1;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int BITPOS_W   = $clog2(CAPACITY * ELEM_BITS) + 1;
  localparam int BYTE_AW    = BITPOS_W - 3;
  localparam int WIN_W      = 2 * BYTE_BITS;

  localparam logic [WIN_W-1:0] ELEM_MASK = WIN_W'((1 << ELEM_BITS) - 1);

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage : pses_pkg

`default_nettype wire

FILE: design/packed_signed_element_store_unit.sv
// Top level of the packed signed element store: sequencer, banks and result registers.
//
// Usage:
//   An access is transferred at a rising edge where start is high and busy is low.
//   kind selects a read (0) or a write (1) of element index; a write keeps the low
//   element bits of write_value and leaves neighboring elements untouched.
//   Elements are packed into two byte banks (even and odd bytes), so the two bytes
//   an element may span are read together and written back together.
//   Timing: the banks are read at the transfer edge, the element is merged or
//   extracted in the following cycle (busy high), and the result is presented on
//   read_value and range_error with done high for exactly one cycle after that.
//   A new access can be transferred in the same cycle that done is high, but not
//   while busy is high, so the block holds one access at a time.
//   The receiver cannot stall; each result is taken in the cycle done is high.
//   range_error flags an index at or above element_count or the capacity; such a
//   write changes nothing and read_value is 0 for every write and every rejection.
//   cfg_we writes cfg_wdata into element_count; write it only while idle.
//   Reset (rst, synchronous) returns the sequencer to idle, clears done and sets
//   element_count to 1024. Bank contents are undefined until written.
`default_nettype none

module packed_signed_element_store_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 kind,
  input  wire logic        [pses_pkg::INDEX_W-1:0]  index,
  input  wire logic signed [pses_pkg::WVAL_W-1:0]   write_value,
  output logic                                      done,
  output logic signed      [pses_pkg::OUT_W-1:0]    read_value,
  output logic                                      range_error,
  input  wire logic                                 cfg_we,
  input  wire logic        [pses_pkg::COUNT_W-1:0]  cfg_wdata
);

  pses_pkg::state_t state;
  pses_pkg::state_t state_next;

  logic [pses_pkg::COUNT_W-1:0] element_count;

  // Request registers captured at the transfer.
  logic                            req_kind;
  logic                            req_bad;
  logic                            req_swap;
  logic [2:0]                      req_off;
  logic [pses_pkg::ELEM_BITS-1:0]  req_wv;
  logic [pses_pkg::BANK_AW-1:0]    req_even_idx;
  logic [pses_pkg::BANK_AW-1:0]    req_odd_idx;

  // Address decode of the incoming index.
  logic                            accept;
  logic                            in_bad;
  logic [pses_pkg::BITPOS_W-1:0]   in_bitpos;
  logic [pses_pkg::BYTE_AW-1:0]    in_byte;
  logic [pses_pkg::BANK_AW-1:0]    in_even_idx;
  logic [pses_pkg::BANK_AW-1:0]    in_odd_idx;

  // Bank ports.
  logic [pses_pkg::BYTE_BITS-1:0]  even_rdata;
  logic [pses_pkg::BYTE_BITS-1:0]  odd_rdata;
  logic [pses_pkg::BYTE_BITS-1:0]  even_wdata;
  logic [pses_pkg::BYTE_BITS-1:0]  odd_wdata;
  logic                            even_we;
  logic                            odd_we;

  // Merge and extract datapath.
  logic [pses_pkg::BYTE_BITS-1:0]  lo_byte;
  logic [pses_pkg::BYTE_BITS-1:0]  hi_byte;
  logic [pses_pkg::WIN_W-1:0]      window;
  logic [pses_pkg::WIN_W-1:0]      field_mask;
  logic [pses_pkg::WIN_W-1:0]      merged;
  logic [pses_pkg::WIN_W-1:0]      shifted;
  logic [pses_pkg::ELEM_BITS-1:0]  elem;
  logic signed [pses_pkg::OUT_W-1:0] elem_ext;
  logic                            spans;
  logic                            lo_we;
  logic                            hi_we;

  assign accept = start && !busy;

  // Range check against the programmed count and the capacity.
  assign in_bad = (32'(index) >= 32'(element_count)) ||
                  (32'(index) >= 32'(pses_pkg::CAPACITY));

  // Bit position, byte address and bank rows for the two bytes of the window.
  assign in_bitpos   = pses_pkg::BITPOS_W'(index[pses_pkg::IDX_W-1:0]) *
                       pses_pkg::BITPOS_W'(pses_pkg::ELEM_BITS);
  assign in_byte     = in_bitpos[pses_pkg::BITPOS_W-1:3];
  assign in_odd_idx  = pses_pkg::BANK_AW'(in_byte >> 1);
  assign in_even_idx = pses_pkg::BANK_AW'((in_byte >> 1) +
                                          pses_pkg::BYTE_AW'(in_byte[0]));

  // Element count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= pses_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      element_count <= cfg_wdata;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pses_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and busy.
  always_comb begin
    state_next = state;
    busy       = 1'b0;
    unique case (state)
      pses_pkg::ST_IDLE: begin
        if (start) begin
          state_next = pses_pkg::ST_EXEC;
        end
      end
      pses_pkg::ST_EXEC: begin
        busy       = 1'b1;
        state_next = pses_pkg::ST_IDLE;
      end
      default: begin
        state_next = pses_pkg::ST_IDLE;
      end
    endcase
  end

  // Capture the request at the transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind     <= kind;
      req_bad      <= in_bad;
      req_swap     <= in_byte[0];
      req_off      <= in_bitpos[2:0];
      req_wv       <= write_value[pses_pkg::ELEM_BITS-1:0];
      req_even_idx <= in_even_idx;
      req_odd_idx  <= in_odd_idx;
    end
  end

  // Byte banks; both are read every cycle at the incoming index.
  pses_ram #(
    .DEPTH (pses_pkg::BANK_DEPTH),
    .WIDTH (pses_pkg::BYTE_BITS)
  ) u_even_bank (
    .clk   (clk),
    .we    (even_we),
    .waddr (req_even_idx),
    .wdata (even_wdata),
    .raddr (in_even_idx),
    .rdata (even_rdata)
  );

  pses_ram #(
    .DEPTH (pses_pkg::BANK_DEPTH),
    .WIDTH (pses_pkg::BYTE_BITS)
  ) u_odd_bank (
    .clk   (clk),
    .we    (odd_we),
    .waddr (req_odd_idx),
    .wdata (odd_wdata),
    .raddr (in_odd_idx),
    .rdata (odd_rdata)
  );

  // Assemble the two-byte window and merge or extract the element.
  always_comb begin
    lo_byte    = req_swap ? odd_rdata : even_rdata;
    hi_byte    = req_swap ? even_rdata : odd_rdata;
    window     = {hi_byte, lo_byte};
    field_mask = pses_pkg::ELEM_MASK << req_off;
    merged     = (window & ~field_mask) |
                 (pses_pkg::WIN_W'(req_wv) << req_off);
    shifted    = window >> req_off;
    elem       = shifted[pses_pkg::ELEM_BITS-1:0];
    elem_ext   = pses_pkg::OUT_W'(signed'(elem));
    spans      = (4'(req_off) + 4'(pses_pkg::ELEM_BITS)) > 4'(pses_pkg::BYTE_BITS);
    lo_we      = busy && req_kind && !req_bad;
    hi_we      = lo_we && spans;
  end

  // Route the low and high bytes back to their banks.
  always_comb begin
    even_we    = req_swap ? hi_we : lo_we;
    odd_we     = req_swap ? lo_we : hi_we;
    even_wdata = req_swap ? merged[pses_pkg::WIN_W-1:pses_pkg::BYTE_BITS]
                          : merged[pses_pkg::BYTE_BITS-1:0];
    odd_wdata  = req_swap ? merged[pses_pkg::BYTE_BITS-1:0]
                          : merged[pses_pkg::WIN_W-1:pses_pkg::BYTE_BITS];
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (busy) begin
      read_value  <= (!req_kind && !req_bad) ? elem_ext : '0;
      range_error <= req_bad;
    end
  end

  // A transfer always leads into the execute cycle.
  assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("transfer did not enter the execute cycle");

  // Every execute cycle produces exactly one result on the next cycle.
  assert property (@(posedge clk) disable iff (rst) busy |=> done && !busy)
    else $error("execute cycle did not deliver a result");

  // A result never appears without a preceding execute cycle.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without an access in flight");

  // Rejected accesses report a zero value.
  assert property (@(posedge clk) disable iff (rst)
    done && range_error |-> read_value == '0)
    else $error("rejected access returned a nonzero value");

  // The bank writes stay within one access and never touch a rejected one.
  assert property (@(posedge clk) disable iff (rst)
    (even_we || odd_we) |-> busy && req_kind && !req_bad)
    else $error("bank written outside a valid write access");

endmodule : packed_signed_element_store_unit

`default_nettype wire

FILE: design/pses_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module pses_ram #(
  parameter int DEPTH = 257,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : pses_ram

`default_nettype wire

FILE: tb/pses_access_checker.sv
// Checker for the packed signed element store: predicts each access and compares its result.
`timescale 1ns / 100ps

module pses_access_checker (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic                                 busy,
  input  wire logic                                 kind,
  input  wire logic        [pses_pkg::INDEX_W-1:0]  index,
  input  wire logic signed [pses_pkg::WVAL_W-1:0]   write_value,
  input  wire logic                                 done,
  input  wire logic signed [pses_pkg::OUT_W-1:0]    read_value,
  input  wire logic                                 range_error,
  input  wire logic                                 cfg_we,
  input  wire logic        [pses_pkg::COUNT_W-1:0]  cfg_wdata,
  output int                                        errors,
  output int                                        outstanding
);

  typedef struct packed {
    logic signed [pses_pkg::OUT_W-1:0] read_value;
    logic                              range_error;
  } access_result_t;

  // Shadow copy of the packed byte memory and of the element count register.
  logic [pses_pkg::BYTE_BITS-1:0] shadow_bytes [pses_pkg::MEM_BYTES];
  logic [pses_pkg::COUNT_W-1:0]   shadow_count;
  access_result_t                 pending_results [$];

  initial begin
    for (int i = 0; i < pses_pkg::MEM_BYTES; i++) shadow_bytes[i] = '0;
  end

  // Applies one access to the shadow memory and returns the result it should produce.
  function automatic access_result_t predict_access(
      input logic is_write,
      input logic [pses_pkg::INDEX_W-1:0] idx,
      input logic [pses_pkg::WVAL_W-1:0] value);
    access_result_t                        res;
    int                                    bitpos;
    int                                    addr;
    int                                    off;
    logic [pses_pkg::WIN_W-1:0]            window;
    logic [pses_pkg::WIN_W-1:0]            field_mask;
    logic signed [pses_pkg::ELEM_BITS-1:0] elem;
    res = '0;
    res.range_error = (idx >= shadow_count) || (idx >= pses_pkg::CAPACITY);
    if (!res.range_error) begin
      bitpos = int'(idx) * pses_pkg::ELEM_BITS;
      addr   = bitpos / pses_pkg::BYTE_BITS;
      off    = bitpos % pses_pkg::BYTE_BITS;
      // The element lies in a two-byte window starting at its first byte.
      window = '0;
      window[pses_pkg::BYTE_BITS-1:0] = shadow_bytes[addr];
      if (addr + 1 < pses_pkg::MEM_BYTES) begin
        window[pses_pkg::WIN_W-1:pses_pkg::BYTE_BITS] = shadow_bytes[addr + 1];
      end
      field_mask = pses_pkg::ELEM_MASK << off;
      if (is_write) begin
        // Merge the low element bits of the value and leave the neighbors alone.
        window = (window & ~field_mask) |
                 ((pses_pkg::WIN_W'(value) & pses_pkg::ELEM_MASK) << off);
        shadow_bytes[addr] = window[pses_pkg::BYTE_BITS-1:0];
        if (off + pses_pkg::ELEM_BITS > pses_pkg::BYTE_BITS) begin
          shadow_bytes[addr + 1] = window[pses_pkg::WIN_W-1:pses_pkg::BYTE_BITS];
        end
      end else begin
        // Gather the element bits and sign-extend them to the output width.
        elem = window[off +: pses_pkg::ELEM_BITS];
        res.read_value = pses_pkg::OUT_W'(elem);
      end
    end
    return res;
  endfunction

  // Watch both channels at the rising edge: retire a result, then record a new transfer.
  always @(posedge clk) begin : monitor
    access_result_t got;
    access_result_t want;
    if (rst) begin
      errors       = 0;
      shadow_count = pses_pkg::COUNT_RESET;
      pending_results.delete();
    end else begin
      if (done) begin
        got.read_value  = read_value;
        got.range_error = range_error;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual read_value %0d %s %0b",
                   $time, got.read_value, "range_error", got.range_error);
        end else begin
          want = pending_results.pop_front();
          if (got.read_value !== want.read_value) begin
            errors++;
            $display("%0t: read_value mismatch: expected %0d, actual %0d",
                     $time, want.read_value, got.read_value);
          end
          if (got.range_error !== want.range_error) begin
            errors++;
            $display("%0t: range_error mismatch: expected %0b, actual %0b",
                     $time, want.range_error, got.range_error);
          end
        end
      end
      // An access at this edge still sees the count from before a write at the same edge.
      if (start && !busy) pending_results.push_back(predict_access(kind, index, write_value));
      if (cfg_we) shadow_count = cfg_wdata;
    end
    outstanding = pending_results.size();
  end

endmodule

FILE: tb/tb_top.sv
// Top of the packed signed element store testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam bit DO_READ       = 1'b0;
  localparam bit DO_WRITE      = 1'b1;
  localparam int ITEMS_PER_SET = 200;
  localparam int NUM_SETS      = 8;
  localparam int CYCLE_LIMIT   = 200000;

  bit clk;
  logic                                 rst         = 1'b1;
  logic                                 start       = 1'b0;
  logic                                 kind        = 1'b0;
  logic        [pses_pkg::INDEX_W-1:0]  index       = '0;
  logic signed [pses_pkg::WVAL_W-1:0]   write_value = '0;
  logic                                 cfg_we      = 1'b0;
  logic        [pses_pkg::COUNT_W-1:0]  cfg_wdata   = '0;
  logic                                 busy;
  logic                                 done;
  logic signed [pses_pkg::OUT_W-1:0]    read_value;
  logic                                 range_error;
  int                                   fail_count;
  int                                   outstanding;
  int                                   cycle_count = 0;

  // Stimulus-side view: current element count and which elements hold a value.
  int element_count_now = pses_pkg::COUNT_RESET;
  bit written [pses_pkg::CAPACITY];
  int hot_base = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  packed_signed_element_store_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .index        (index),
    .write_value  (write_value),
    .done         (done),
    .read_value   (read_value),
    .range_error  (range_error),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  pses_access_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .index        (index),
    .write_value  (write_value),
    .done         (done),
    .read_value   (read_value),
    .range_error  (range_error),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .errors       (fail_count),
    .outstanding  (outstanding)
  );

  // Guard against a hung handshake or a lost result.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Number of indices that the block accepts under the current count.
  function automatic int usable_limit();
    return (element_count_now < pses_pkg::CAPACITY) ? element_count_now : pses_pkg::CAPACITY;
  endfunction

  // Present one access after an optional gap and hold it until it transfers.
  task automatic send_access(input bit is_write, input int idx,
                             input logic [pses_pkg::WVAL_W-1:0] value, input int gap);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    kind        <= is_write;
    index       <= pses_pkg::INDEX_W'(idx);
    write_value <= value;
    if (is_write && idx < usable_limit()) written[idx] = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop sending and wait until every expected result has arrived.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the element count register; only called while the block is idle.
  task automatic set_element_count(input int value);
    @(negedge clk);
    cfg_we            <= 1'b1;
    cfg_wdata         <= pses_pkg::COUNT_W'(value);
    element_count_now = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly valid accesses, many near one hot spot so neighbors share bytes,
  // with some rejected indices; a read never targets an element not yet written.
  task automatic random_access(input int gap);
    int lim;
    int sel;
    int idx;
    bit is_write;
    lim      = usable_limit();
    sel      = $urandom_range(0, 99);
    is_write = $urandom_range(0, 1);
    if (lim == 0 || sel < 12) begin
      idx = (sel < 6) ? $urandom_range(0, 65535) : $urandom_range(lim, lim + 40);
    end else if (sel < 55) begin
      idx = (hot_base + $urandom_range(0, 7)) % lim;
    end else begin
      idx = $urandom_range(0, lim - 1);
    end
    if (idx < lim && !is_write && !written[idx]) is_write = DO_WRITE;
    send_access(is_write, idx, pses_pkg::WVAL_W'($urandom_range(0, 255)), gap);
  endtask

  initial begin : stimulus
    int set_counts [NUM_SETS];
    int gap_mode;
    int gap;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed part: value extremes, both ends of the array, neighbors in one
    // byte, back-to-back writes of one element, and rejected indices.
    send_access(DO_WRITE, 0, 8'h80, 0);
    send_access(DO_WRITE, 1, 8'h7F, 0);
    send_access(DO_WRITE, 2, 8'h07, 0);
    send_access(DO_WRITE, 3, 8'h08, 0);
    send_access(DO_WRITE, pses_pkg::CAPACITY - 1, 8'hFF, 0);
    send_access(DO_WRITE, pses_pkg::CAPACITY - 2, 8'h55, 0);
    send_access(DO_READ, 0, 8'h00, 0);
    send_access(DO_READ, 1, 8'hFF, 0);
    send_access(DO_READ, 2, 8'h00, 0);
    send_access(DO_READ, 3, 8'h00, 0);
    send_access(DO_READ, pses_pkg::CAPACITY - 1, 8'h00, 0);
    send_access(DO_READ, pses_pkg::CAPACITY - 2, 8'h00, 0);
    send_access(DO_WRITE, 5, 8'h0A, 0);
    send_access(DO_WRITE, 4, 8'h03, 0);
    send_access(DO_READ, 4, 8'h00, 0);
    send_access(DO_READ, 5, 8'h00, 0);
    send_access(DO_WRITE, 6, 8'h01, 0);
    send_access(DO_WRITE, 6, 8'h0E, 0);
    send_access(DO_READ, 6, 8'h00, 0);
    send_access(DO_WRITE, pses_pkg::CAPACITY, 8'h33, 3);
    send_access(DO_READ, pses_pkg::CAPACITY, 8'h00, 0);
    send_access(DO_WRITE, 65535, 8'hFF, 0);
    send_access(DO_READ, 65535, 8'h00, 0);
    send_access(DO_READ, 1, 8'h00, 12);
    wait_drained();

    // Random part: one element count per set, the extremes among them.
    set_counts = '{1024, 2047, 0, 1, 1023, 8, 600, 0};
    set_counts[NUM_SETS - 1] = $urandom_range(0, 2047);
    for (int s = 0; s < NUM_SETS; s++) begin
      set_element_count(set_counts[s]);
      gap_mode = 0;
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        if (n % 50 == 0) gap_mode = $urandom_range(0, 2);
        if (n % 50 == 0 && usable_limit() > 0) hot_base = $urandom_range(0, usable_limit() - 1);
        case (gap_mode)
          0: gap = 0;
          1: gap = $urandom_range(0, 12);
          default: gap = $urandom_range(0, 2);
        endcase
        random_access(gap);
      end
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
